/* design/b64d_pkg.sv */
package b64d_pkg;

   // Default depth of the job queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Alphabet anchors
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   // Classified character
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // Work handed from front to back: up to three bytes, oldest in the top byte.
   // A count of zero means a marker-only item.
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  count;
      logic        last;
   } job_type;

   function automatic sextet_type decode_sextet(input logic [7:0] c);
      sextet_type s;
      logic [7:0] diff;
      s    = '0;
      diff = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         diff    = c - CHAR_UPPER_A;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         diff    = c - CHAR_LOWER_A + LOWER_BASE;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         diff    = c - CHAR_DIGIT_0 + DIGIT_BASE;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c == CHAR_PLUS) begin
         s.valid = 1'b1;
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.valid = 1'b1;
         s.value = SEXTET_SLASH;
      end
      return s;
   endfunction

endpackage

/* design/base64_stream_decoder_core.sv */
// Streaming base64 decoder, standard A-Z a-z 0-9 + / alphabet. One character
// is taken per cycle through push/full; decoded bytes leave one per cycle
// through empty/pop. Each group of four characters yields three byte items.
// The first '=' or non-alphabet character ends decoding, and the rest of the
// message is dropped. On the character flagged message_end a partial group
// of n sextets gives n-1 bytes, the final item carries last_of_message, and
// a message that ends with no byte gives one item with byte_present low.
// The front classifies characters and packs bytes into jobs; a job queue of
// QUEUE_DEPTH entries feeds the back, which emits one item per cycle. Input
// and output throughput are one item per cycle each; results pass the queue,
// then the output register. full rises only while the queue is full, i.e.
// when results are not being popped or a burst of flush jobs is draining.
module base64_stream_decoder_core #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_message_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_byte_present,
   output logic       rsp_last_of_message
);

   b64d_pkg::job_type front_job, head_job;
   logic              job_push, job_pop, job_empty;
   logic              accept;

   assign accept = req_push && !req_full;

   // Character classification and grouping
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .message_end (req_message_end),
      .job_push    (job_push),
      .job         (front_job)
   );

   // Decoupling queue
   b64d_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head     (head_job)
   );

   // Byte serializer and output register
   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (job_empty),
      .job             (head_job),
      .job_pop         (job_pop),
      .out_pop         (rsp_pop),
      .out_empty       (rsp_empty),
      .byte_value      (rsp_byte_value),
      .byte_present    (rsp_byte_present),
      .last_of_message (rsp_last_of_message)
   );

endmodule

/* design/b64d_front.sv */
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_code,
   input  logic              message_end,
   output logic              job_push,
   output b64d_pkg::job_type job
);

   logic [17:0] group_ff, group_in;
   logic [1:0]  fill_ff, fill_in;
   logic        stopped_ff, stopped_in;

   b64d_pkg::sextet_type sx;
   logic [17:0] group_mid;
   logic [1:0]  fill_mid;

   // Gather sextets, build a job for full groups and end-of-message flushes
   always_comb begin
      sx         = b64d_pkg::decode_sextet(char_code);
      group_mid  = group_ff;
      fill_mid   = fill_ff;
      stopped_in = stopped_ff;
      job        = '0;
      if (!stopped_ff) begin
         if (!sx.valid) begin
            stopped_in = 1'b1;
         end else if (fill_ff == 2'd3) begin
            job.data  = {group_ff, sx.value};
            job.count = 2'd3;
            group_mid = '0;
            fill_mid  = '0;
         end else begin
            group_mid = {group_ff[11:0], sx.value};
            fill_mid  = fill_ff + 2'd1;
         end
      end
      group_in = group_mid;
      fill_in  = fill_mid;
      if (message_end) begin
         // partial group of n sextets flushes n-1 bytes
         case (fill_mid)
            2'd2: begin
               job.data  = {group_mid[11:4], 16'h0000};
               job.count = 2'd1;
            end
            2'd3: begin
               job.data  = {group_mid[17:10], group_mid[9:2], 8'h00};
               job.count = 2'd2;
            end
            default: ;
         endcase
         job.last   = 1'b1;
         group_in   = '0;
         fill_in    = '0;
         stopped_in = 1'b0;
      end
      job_push = accept && (job.count != 2'd0 || message_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff   <= '0;
         fill_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         group_ff   <= group_in;
         fill_ff    <= fill_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

/* design/b64d_job_queue.sv */
module b64d_job_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output b64d_pkg::job_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   b64d_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/b64d_back.sv */
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  b64d_pkg::job_type job,
   output logic              job_pop,
   input  logic              out_pop,
   output logic              out_empty,
   output logic [7:0]        byte_value,
   output logic              byte_present,
   output logic              last_of_message
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] value_ff, value_in;
   logic       present_ff, present_in;
   logic       last_ff, last_in;
   logic       slot_free, emit, final_item;
   logic [1:0] last_idx;

   assign out_empty       = !out_valid_ff;
   assign byte_value      = value_ff;
   assign byte_present    = present_ff;
   assign last_of_message = last_ff;

   // Walk the head job one item at a time into the output register
   always_comb begin
      slot_free    = !out_valid_ff || out_pop;
      emit         = slot_free && !job_empty;
      last_idx     = (job.count == 2'd0) ? 2'd0 : job.count - 2'd1;
      final_item   = (idx_ff == last_idx);
      job_pop      = emit && final_item;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      value_in     = value_ff;
      present_in   = present_ff;
      last_in      = last_ff;
      if (emit) begin
         case (idx_ff)
            2'd0:    value_in = job.data[23:16];
            2'd1:    value_in = job.data[15:8];
            default: value_in = job.data[7:0];
         endcase
         present_in   = (job.count != 2'd0);
         last_in      = job.last && final_item;
         out_valid_in = 1'b1;
         idx_in       = final_item ? 2'd0 : idx_ff + 2'd1;
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      present_ff <= present_in;
      last_ff    <= last_in;
   end

endmodule

/* tb/b64_decode_checker.sv */
`timescale 1ns / 1ps

// Watches both queue ports of the decoder, predicts the decoded bytes of
// every accepted character and compares them in order with what is popped.
module b64_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_message_end,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_byte_value,
   input  logic       rsp_byte_present,
   input  logic       rsp_last_of_message,
   output int         fail_count,
   output int         pending,
   output int         checked
);

   localparam logic [6:0] NOT_IN_ALPHABET = 7'h40;
   localparam int         PRINT_CAP       = 40;

   typedef struct {
      logic [7:0] value;
      logic       present;
      logic       last;
   } decoded_byte_type;

   // Bytes still owed by the decoder, oldest first
   decoded_byte_type expected_bytes[$];

   // Predictor state: pending sextets (newest low), their count, stop flag
   logic [17:0] group_bits  = '0;
   logic [1:0]  group_count = '0;
   logic        stopped     = 1'b0;

   int errors  = 0;
   int matched = 0;

   task automatic report_mismatch(input string what);
      if (errors < PRINT_CAP)
         $display("t=%0t mismatch: %s", $time, what);
      errors++;
   endtask

   // Bit 6 set marks a character outside the alphabet
   function automatic logic [6:0] sextet_for(input logic [7:0] ch);
      logic [7:0] offset;
      offset = '0;
      if (ch >= b64d_pkg::CHAR_UPPER_A && ch <= b64d_pkg::CHAR_UPPER_Z)
         offset = ch - b64d_pkg::CHAR_UPPER_A;
      else if (ch >= b64d_pkg::CHAR_LOWER_A && ch <= b64d_pkg::CHAR_LOWER_Z)
         offset = ch - b64d_pkg::CHAR_LOWER_A + b64d_pkg::LOWER_BASE;
      else if (ch >= b64d_pkg::CHAR_DIGIT_0 && ch <= b64d_pkg::CHAR_DIGIT_9)
         offset = ch - b64d_pkg::CHAR_DIGIT_0 + b64d_pkg::DIGIT_BASE;
      else if (ch == b64d_pkg::CHAR_PLUS)
         offset = {2'b00, b64d_pkg::SEXTET_PLUS};
      else if (ch == b64d_pkg::CHAR_SLASH)
         offset = {2'b00, b64d_pkg::SEXTET_SLASH};
      else
         return NOT_IN_ALPHABET;
      return {1'b0, offset[5:0]};
   endfunction

   // Update the prediction for one accepted character
   task automatic decode_char(input logic [7:0] ch, input logic at_end);
      logic [6:0]       sx;
      logic [23:0]      word;
      logic [7:0]       out_bytes[3];
      int               n;
      decoded_byte_type item;
      n = 0;
      if (!stopped) begin
         sx = sextet_for(ch);
         if (sx[6]) begin
            stopped = 1'b1;
         end else if (group_count == 2'd3) begin
            word = {group_bits, sx[5:0]};
            out_bytes[0] = word[23:16];
            out_bytes[1] = word[15:8];
            out_bytes[2] = word[7:0];
            n = 3;
            group_bits  = '0;
            group_count = '0;
         end else begin
            group_bits  = {group_bits[11:0], sx[5:0]};
            group_count = group_count + 2'd1;
         end
      end
      // Partial group flush at message end
      if (at_end) begin
         if (group_count == 2'd2) begin
            out_bytes[n] = group_bits[11:4];
            n++;
         end else if (group_count == 2'd3) begin
            out_bytes[n] = group_bits[17:10];
            out_bytes[n + 1] = group_bits[9:2];
            n += 2;
         end
      end
      for (int i = 0; i < n; i++) begin
         item.value   = out_bytes[i];
         item.present = 1'b1;
         item.last    = at_end && (i == n - 1);
         expected_bytes.push_back(item);
      end
      // Nothing decoded on the end character: marker-only item
      if (at_end && n == 0) begin
         item.value   = '0;
         item.present = 1'b0;
         item.last    = 1'b1;
         expected_bytes.push_back(item);
      end
      if (at_end) begin
         group_bits  = '0;
         group_count = '0;
         stopped     = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         group_bits  = '0;
         group_count = '0;
         stopped     = 1'b0;
      end else begin
         if (req_push && !req_full)
            decode_char(req_char_code, req_message_end);
         // Compare the popped item with the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected item value=%02h present=%0b last=%0b",
                  rsp_byte_value, rsp_byte_present, rsp_last_of_message));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_byte_value !== want.value)
                  report_mismatch($sformatf("byte_value %02h, want %02h",
                     rsp_byte_value, want.value));
               if (rsp_byte_present !== want.present)
                  report_mismatch($sformatf("byte_present %0b, want %0b",
                     rsp_byte_present, want.present));
               if (rsp_last_of_message !== want.last)
                  report_mismatch($sformatf("last_of_message %0b, want %0b",
                     rsp_last_of_message, want.last));
               matched++;
            end
         end
      end
      pending    <= expected_bytes.size();
      fail_count <= errors;
      checked    <= matched;
   end

endmodule

/* tb/tb_base64_stream_decoder_core.sv */
`timescale 1ns / 1ps

module tb_base64_stream_decoder_core;

   localparam int         RANDOM_ITEMS = 280;
   localparam int         HOLD_CYCLES  = 120;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam logic [7:0] CHAR_PAD     = 8'h3d;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_push            = 1'b0;
   logic       req_full;
   logic [7:0] req_char_code       = '0;
   logic       req_message_end     = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop             = 1'b0;
   logic [7:0] rsp_byte_value;
   logic       rsp_byte_present;
   logic       rsp_last_of_message;

   int fail_count;
   int pending;
   int checked;

   int cycle_count = 0;
   int chars_sent  = 0;
   int live_items  = 0;
   int messages    = 0;
   int hold_left   = 0;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   bit hold_taken   = 1'b0;

   base64_stream_decoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_char_code       (req_char_code),
      .req_message_end     (req_message_end),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_byte_present    (rsp_byte_present),
      .rsp_last_of_message (rsp_last_of_message)
   );

   b64_decode_checker decode_check (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_char_code       (req_char_code),
      .req_message_end     (req_message_end),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_byte_present    (rsp_byte_present),
      .rsp_last_of_message (rsp_last_of_message),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked             (checked)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Output side: random pops, steady stretches, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_pop    <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (steady) begin
         rsp_pop <= 1'b1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= 18);
      end
   end

   function automatic logic [7:0] char_for_sextet(input logic [5:0] v);
      if (v < 6'd26)
         return b64d_pkg::CHAR_UPPER_A + {2'b00, v};
      if (v < 6'd52)
         return b64d_pkg::CHAR_LOWER_A + {2'b00, v} - b64d_pkg::LOWER_BASE;
      if (v < 6'd62)
         return b64d_pkg::CHAR_DIGIT_0 + {2'b00, v} - b64d_pkg::DIGIT_BASE;
      return (v == b64d_pkg::SEXTET_PLUS) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
   endfunction

   // Some byte that is not in the alphabet
   function automatic logic [7:0] pick_stop_char();
      case ($urandom_range(3))
         0:       return CHAR_PAD;
         1:       return 8'($urandom_range(8'h2a));
         2:       return 8'($urandom_range(255, 8'h7b));
         default: return 8'($urandom_range(8'h40, 8'h3a));
      endcase
   endfunction

   // Offer one character and wait until it is taken
   task automatic send_char(input logic [7:0] ch, input logic at_end, input bit counted);
      // idle cycles drawn one at a time
      while (!steady && $urandom_range(99) < 18) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_char_code   <= ch;
      req_message_end <= at_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chars_sent++;
      if (counted)
         live_items++;
      if (at_end)
         messages++;
   endtask

   task automatic send_text(input string s, input bit end_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], end_last && (i == s.len() - 1), 1'b1);
   endtask

   task automatic send_random_message();
      int kind, groups, tail, nvalid, pad, len, stop_at;
      kind = $urandom_range(99);
      if (kind < 70) begin
         // well-formed: full groups, a tail, optional padding
         groups = $urandom_range(3);
         tail   = $urandom_range(3);
         if (groups == 0 && tail == 0)
            groups = 1;
         nvalid = groups * 4 + tail;
         pad    = (tail != 0 && $urandom_range(1) == 1) ? 4 - tail : 0;
         for (int i = 0; i < nvalid; i++)
            send_char(char_for_sextet(6'($urandom_range(63))),
                      pad == 0 && i == nvalid - 1, 1'b1);
         for (int i = 0; i < pad; i++)
            send_char(CHAR_PAD, i == pad - 1, i == 0);
      end else if (kind < 85) begin
         // broken: a stop character somewhere, rest ignored
         len     = $urandom_range(10, 1);
         stop_at = $urandom_range(len - 1);
         for (int i = 0; i < len; i++)
            send_char((i == stop_at) ? pick_stop_char()
                                     : char_for_sextet(6'($urandom_range(63))),
                      i == len - 1, i <= stop_at);
      end else begin
         // raw noise bytes
         len = $urandom_range(6, 1);
         for (int i = 0; i < len; i++)
            send_char(8'($urandom_range(255)), i == len - 1, 1'b1);
      end
   endtask

   initial begin
      int start_items;
      int rand_msgs;
      rand_msgs = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: full group, padded tails, lone sextet, stop and ignored chars
      send_text("TWFu", 1'b1);
      send_text("TWE=", 1'b1);
      send_text("TQ==", 1'b1);
      send_text("Q", 1'b1);
      send_text("=", 1'b1);
      send_char(8'h00, 1'b1, 1'b1);
      send_text("zZ09/+", 1'b0);
      send_char(8'hff, 1'b0, 1'b1);
      send_text("AB", 1'b1);
      send_char(8'h80, 1'b1, 1'b1);
      send_text("a9", 1'b1);

      // Random messages
      start_items = live_items;
      while (live_items - start_items < RANDOM_ITEMS) begin
         if (rand_msgs == 5)
            hold_request <= 1'b1;
         steady <= (rand_msgs >= 30 && rand_msgs < 42);
         send_random_message();
         rand_msgs++;
      end
      req_push <= 1'b0;
      steady   <= 1'b0;

      // Drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d characters in %0d messages; %0d decoded items checked",
               chars_sent, messages, checked);
      $display("Covered padding, stop bytes, ignored tails, marker-only ends, %0d-cycle stall",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_job_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_core.sv
tb/b64_decode_checker.sv
tb/tb_base64_stream_decoder_core.sv
